// ===== design/five_stage_pipeline_core_assert.svh =====
// Assertion macros for the checker file of this block.
`ifndef FIVE_STAGE_PIPELINE_CORE_ASSERT_SVH
`define FIVE_STAGE_PIPELINE_CORE_ASSERT_SVH

// Clocked assertion that is quiet while reset is applied.
`define FSPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is also checked across the reset release.
`define FSPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/fspc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fspc_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_STEP     = 2'd1,
    CMD_READ_REG = 2'd2,
    CMD_READ_MEM = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_NOR  = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } op_e;

  localparam logic [31:0] NOOP_WORD = 32'h01c0_0000;
  localparam int          RegCount  = 8;

  typedef struct packed {
    logic        halted;
    logic [9:0]  program_counter;
    logic [31:0] cycle_count;
    logic [31:0] read_value;
    logic        reg_write_valid;
    logic [2:0]  reg_write_index;
    logic [31:0] reg_write_value;
    logic        store_valid;
    logic [9:0]  store_address;
    logic [31:0] store_value;
  } res_t;

endpackage

`default_nettype wire

// ===== design/five_stage_pipeline_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Five-stage LC-2K pipeline driven one command per transaction.
// Slave channel: s_axis_tuser carries the command (load word, step the
// pipeline, read register, read data word); s_axis_tdata carries the address
// and the data word. Every accepted transaction returns exactly one result
// transaction on the master channel with the halt flag, fetch address,
// clock count, read value and the register and store writes of that step.
// An accepted transaction is held in the input register and its result is
// loaded into the output register; a new transaction is accepted every
// cycle while the receiver takes results: the input register feeds one pass
// of pipeline logic whose result lands in the output register.
// Instruction and data memory reads come from registered read ports that
// are aimed at the next fetch address, load address and read address.
// After reset both memories are cleared by a pass over all 2**MEM_ADDR_BITS
// words, one word per cycle, with s_axis_tready held low; the pipeline
// latches, register file and counters are cleared at once.
// When the receiver stalls the result holds in the output register, one
// more transaction waits in the input register, and then tready drops.
module five_stage_pipeline_core #(
  parameter int MEM_ADDR_BITS = 10
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // address [9:0], data [41:10], zero fill up to 48 bits
  input  wire logic [47:0]  s_axis_tdata,
  // command [1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // halted [0], program_counter [10:1], cycle_count [42:11],
  // read_value [74:43], reg_write_valid [75], reg_write_index [78:76],
  // reg_write_value [110:79], store_valid [111], store_address [121:112],
  // store_value [153:122], zero fill up to 160 bits
  output logic [159:0]      m_axis_tdata
);

  localparam int AW = MEM_ADDR_BITS;

  logic           clearing_q;
  logic [AW-1:0]  clr_cnt_q;
  logic           s1_v_q;
  fspc_pkg::cmd_e s1_cmd_q;
  logic [9:0]     s1_addr_q;
  logic [31:0]    s1_data_q;
  logic           out_v_q;
  logic [159:0]   out_q;
  logic           advance, accept;
  fspc_pkg::res_t res;

  // The command in the input register runs when the output register is
  // free or being emptied in the same cycle.
  assign advance       = s1_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !clearing_q && (!s1_v_q || advance);
  assign accept        = s_axis_tvalid && s_axis_tready;

  fspc_core #(
    .MEM_ADDR_BITS(MEM_ADDR_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (clearing_q),
    .clr_addr_i (clr_cnt_q),
    .rd_en_i    (accept),
    .rd_addr_i  (s_axis_tdata[9:0]),
    .go_i       (advance),
    .cmd_i      (s1_cmd_q),
    .addr_i     (s1_addr_q),
    .data_i     (s1_data_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      s1_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == {AW{1'b1}}) clearing_q <= 1'b0;
      end
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (advance) begin
        s1_v_q <= 1'b0;
      end
      if (advance) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q  <= fspc_pkg::cmd_e'(s_axis_tuser);
      s1_addr_q <= s_axis_tdata[9:0];
      s1_data_q <= s_axis_tdata[41:10];
    end
    if (advance) begin
      out_q <= {6'd0, res.store_value, res.store_address, res.store_valid,
                res.reg_write_value, res.reg_write_index, res.reg_write_valid,
                res.read_value, res.cycle_count, res.program_counter, res.halted};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

// ===== design/fspc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fspc_core #(
  parameter int MEM_ADDR_BITS = 10
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     clear_i,
  input  wire logic [MEM_ADDR_BITS-1:0] clr_addr_i,
  input  wire logic                     rd_en_i,
  input  wire logic [9:0]               rd_addr_i,
  input  wire logic                     go_i,
  input  wire fspc_pkg::cmd_e           cmd_i,
  input  wire logic [9:0]               addr_i,
  input  wire logic [31:0]              data_i,
  output fspc_pkg::res_t                res_o
);

  localparam int AW    = MEM_ADDR_BITS;
  localparam int Depth = 1 << AW;

  function automatic fspc_pkg::op_e op_of(input logic [31:0] w);
    return fspc_pkg::op_e'(w[24:22]);
  endfunction

  function automatic logic writes_reg(input fspc_pkg::op_e op);
    return (op == fspc_pkg::OP_ADD) || (op == fspc_pkg::OP_NOR) || (op == fspc_pkg::OP_LW);
  endfunction

  function automatic logic uses_a(input fspc_pkg::op_e op);
    return (op == fspc_pkg::OP_ADD) || (op == fspc_pkg::OP_NOR) || (op == fspc_pkg::OP_LW) ||
           (op == fspc_pkg::OP_SW) || (op == fspc_pkg::OP_BEQ);
  endfunction

  function automatic logic uses_b(input fspc_pkg::op_e op);
    return (op == fspc_pkg::OP_ADD) || (op == fspc_pkg::OP_NOR) ||
           (op == fspc_pkg::OP_SW) || (op == fspc_pkg::OP_BEQ);
  endfunction

  logic [31:0] imem [Depth];
  logic [31:0] dmem [Depth];

  logic [AW-1:0] fa_q;
  logic [31:0]   inst_q [5];
  logic [AW-1:0] pcn_q [2];
  logic [31:0]   dop_q [3];
  logic [AW-1:0] ex_tgt_q;
  logic [31:0]   ex_alu_q;
  logic [31:0]   ex_b_q;
  logic [31:0]   wbv_q [2];
  logic [2:0]    dst_q [4];
  logic [31:0]   cyc_q;
  logic          halt_q;
  logic [31:0]   rf_q [fspc_pkg::RegCount];
  logic [31:0]   if_word_q, ld_word_q, rd_word_q;

  logic [AW-1:0] fa_d;
  logic [31:0]   ni [5];
  logic [AW-1:0] np [2];
  logic [31:0]   nd [3];
  logic [AW-1:0] ne_tgt;
  logic [31:0]   ne_alu, ne_b;
  logic [31:0]   nw [2];
  logic [2:0]    nt [4];
  logic          halt_d, step, stall, rf_we;
  logic [2:0]    rf_wa;
  logic [31:0]   a_val, b_val;
  fspc_pkg::op_e oif, oid, oex, omw, owb;
  logic          im_we, dm_we;
  logic [AW-1:0] im_wa, dm_wa, ld_addr, rd_addr;
  logic [31:0]   im_wd, dm_wd;
  logic [31:0]   alu_d;

  always_comb begin
    step = go_i && (cmd_i == fspc_pkg::CMD_STEP) && !halt_q;
    oif  = op_of(inst_q[0]);
    oid  = op_of(inst_q[1]);
    oex  = op_of(inst_q[2]);
    omw  = op_of(inst_q[3]);
    owb  = op_of(inst_q[4]);
    for (int i = 0; i < 5; i++) ni[i] = inst_q[i];
    for (int i = 0; i < 2; i++) np[i] = pcn_q[i];
    for (int i = 0; i < 3; i++) nd[i] = dop_q[i];
    for (int i = 0; i < 2; i++) nw[i] = wbv_q[i];
    for (int i = 0; i < 4; i++) nt[i] = dst_q[i];
    fa_d   = fa_q;
    ne_alu = ex_alu_q;

    // Load-use hazard: hold fetch and decode, send a bubble into execute.
    stall = 1'b0;
    if (oid == fspc_pkg::OP_LW) begin
      if (((oif == fspc_pkg::OP_ADD) || (oif == fspc_pkg::OP_NOR) ||
           (oif == fspc_pkg::OP_BEQ) || (oif == fspc_pkg::OP_SW)) &&
          ((inst_q[0][21:19] == inst_q[1][18:16]) || (inst_q[0][18:16] == inst_q[1][18:16]))) begin
        stall = 1'b1;
      end else if ((oif == fspc_pkg::OP_LW) && (inst_q[0][21:19] == inst_q[1][18:16])) begin
        stall = 1'b1;
      end
    end
    if (stall) begin
      ni[1] = fspc_pkg::NOOP_WORD;
    end else begin
      ni[0] = if_word_q;
      np[0] = fa_q + AW'(1);
      fa_d  = fa_q + AW'(1);
      ni[1] = inst_q[0];
    end

    np[1] = pcn_q[0];
    nd[0] = rf_q[inst_q[0][21:19]];
    nd[1] = rf_q[inst_q[0][18:16]];
    nd[2] = {{16{inst_q[0][15]}}, inst_q[0][15:0]};
    if ((oif == fspc_pkg::OP_ADD) || (oif == fspc_pkg::OP_NOR)) begin
      nt[0] = inst_q[0][2:0];
    end else if (oif == fspc_pkg::OP_LW) begin
      nt[0] = inst_q[0][18:16];
    end

    // Execute, with the nearest forwarding source taking priority.
    ni[2]  = inst_q[1];
    ne_tgt = pcn_q[1] + AW'(dop_q[2]);
    nt[1]  = dst_q[0];
    a_val  = dop_q[0];
    b_val  = dop_q[1];
    if (writes_reg(owb)) begin
      if ((dst_q[3] == inst_q[1][21:19]) && uses_a(oid)) a_val = wbv_q[1];
      if ((dst_q[3] == inst_q[1][18:16]) && uses_b(oid)) b_val = wbv_q[1];
    end
    if (writes_reg(omw)) begin
      if ((dst_q[2] == inst_q[1][21:19]) && uses_a(oid)) a_val = wbv_q[0];
      if ((dst_q[2] == inst_q[1][18:16]) && uses_b(oid)) b_val = wbv_q[0];
    end
    if ((oex == fspc_pkg::OP_ADD) || (oex == fspc_pkg::OP_NOR)) begin
      if ((dst_q[1] == inst_q[1][21:19]) && uses_a(oid)) a_val = ex_alu_q;
      if ((dst_q[1] == inst_q[1][18:16]) && uses_b(oid)) b_val = ex_alu_q;
    end
    case (oid)
      fspc_pkg::OP_ADD: ne_alu = a_val + b_val;
      fspc_pkg::OP_NOR: ne_alu = ~(a_val | b_val);
      fspc_pkg::OP_LW,
      fspc_pkg::OP_SW:  ne_alu = a_val + dop_q[2];
      fspc_pkg::OP_BEQ: ne_alu = b_val - a_val;
      default:          ne_alu = ex_alu_q;
    endcase
    ne_b = b_val;

    // Memory stage; a taken branch flushes the three younger latches.
    ni[3] = inst_q[2];
    nt[2] = dst_q[1];
    case (oex)
      fspc_pkg::OP_ADD,
      fspc_pkg::OP_NOR,
      fspc_pkg::OP_SW:  nw[0] = ex_alu_q;
      fspc_pkg::OP_LW:  nw[0] = ld_word_q;
      fspc_pkg::OP_BEQ: begin
        if (ex_alu_q == 32'd0) begin
          ni[0] = fspc_pkg::NOOP_WORD;
          ni[1] = fspc_pkg::NOOP_WORD;
          ni[2] = fspc_pkg::NOOP_WORD;
          fa_d  = ex_tgt_q;
        end
      end
      default: ;
    endcase

    ni[4]  = inst_q[3];
    nt[3]  = dst_q[2];
    nw[1]  = wbv_q[0];
    rf_we  = step && writes_reg(omw);
    rf_wa  = dst_q[2];
    halt_d = (op_of(ni[3]) == fspc_pkg::OP_HALT);

    if (!step) begin
      fa_d   = fa_q;
      ne_alu = ex_alu_q;
    end
    alu_d = ne_alu;

    im_we = 1'b0;
    im_wa = clr_addr_i;
    im_wd = 32'd0;
    dm_we = 1'b0;
    dm_wa = clr_addr_i;
    dm_wd = 32'd0;
    if (clear_i) begin
      im_we = 1'b1;
      dm_we = 1'b1;
    end else if (go_i && (cmd_i == fspc_pkg::CMD_LOAD)) begin
      im_we = 1'b1;
      im_wa = AW'(addr_i);
      im_wd = data_i;
      dm_we = 1'b1;
      dm_wa = AW'(addr_i);
      dm_wd = data_i;
    end else if (step && (oex == fspc_pkg::OP_SW)) begin
      dm_we = 1'b1;
      dm_wa = AW'(ex_alu_q);
      dm_wd = ex_b_q;
    end
    ld_addr = AW'(alu_d);
    rd_addr = AW'(rd_addr_i);

    res_o.halted          = step ? halt_d : halt_q;
    res_o.program_counter = 10'(fa_d);
    res_o.cycle_count     = step ? (cyc_q + 32'd1) : cyc_q;
    res_o.read_value      = 32'd0;
    if (go_i && (cmd_i == fspc_pkg::CMD_READ_REG)) res_o.read_value = rf_q[addr_i[2:0]];
    if (go_i && (cmd_i == fspc_pkg::CMD_READ_MEM)) res_o.read_value = rd_word_q;
    res_o.reg_write_valid = rf_we;
    res_o.reg_write_index = rf_we ? rf_wa : 3'd0;
    res_o.reg_write_value = rf_we ? wbv_q[0] : 32'd0;
    res_o.store_valid     = step && (oex == fspc_pkg::OP_SW);
    res_o.store_address   = res_o.store_valid ? 10'(AW'(ex_alu_q)) : 10'd0;
    res_o.store_value     = res_o.store_valid ? ex_b_q : 32'd0;
  end

  // Memories; the read words are kept equal to the word at their address
  // by passing a same-cycle write straight through.
  always_ff @(posedge clk_i) begin
    if (im_we) imem[im_wa] <= im_wd;
    if (dm_we) dmem[dm_wa] <= dm_wd;
    if_word_q <= (im_we && (im_wa == fa_d)) ? im_wd : imem[fa_d];
    ld_word_q <= (dm_we && (dm_wa == ld_addr)) ? dm_wd : dmem[ld_addr];
    if (rd_en_i) begin
      rd_word_q <= (dm_we && (dm_wa == rd_addr)) ? dm_wd : dmem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fa_q     <= '0;
      for (int i = 0; i < 5; i++) inst_q[i] <= fspc_pkg::NOOP_WORD;
      for (int i = 0; i < 2; i++) pcn_q[i] <= '0;
      for (int i = 0; i < 3; i++) dop_q[i] <= '0;
      for (int i = 0; i < 2; i++) wbv_q[i] <= '0;
      for (int i = 0; i < 4; i++) dst_q[i] <= '0;
      for (int i = 0; i < fspc_pkg::RegCount; i++) rf_q[i] <= '0;
      ex_tgt_q <= '0;
      ex_alu_q <= '0;
      ex_b_q   <= '0;
      cyc_q    <= '0;
      halt_q   <= 1'b0;
    end else if (step) begin
      fa_q     <= fa_d;
      for (int i = 0; i < 5; i++) inst_q[i] <= ni[i];
      for (int i = 0; i < 2; i++) pcn_q[i] <= np[i];
      for (int i = 0; i < 3; i++) dop_q[i] <= nd[i];
      for (int i = 0; i < 2; i++) wbv_q[i] <= nw[i];
      for (int i = 0; i < 4; i++) dst_q[i] <= nt[i];
      if (rf_we) rf_q[rf_wa] <= wbv_q[0];
      ex_tgt_q <= ne_tgt;
      ex_alu_q <= ne_alu;
      ex_b_q   <= ne_b;
      cyc_q    <= cyc_q + 32'd1;
      halt_q   <= halt_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/fspc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "five_stage_pipeline_core_assert.svh"

module fspc_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [47:0]  s_axis_tdata,
  input wire logic [1:0]   s_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [159:0] m_axis_tdata
);

  `FSPC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
  `FSPC_ASSERT_ALWAYS(a_clear_after_reset, $rose(rst_ni) |-> !s_axis_tready, "ready during clear")
  `FSPC_ASSERT(a_rw_zero, m_axis_tvalid && !m_axis_tdata[75] |-> m_axis_tdata[110:76] == 35'd0, "stray register write")
  `FSPC_ASSERT(a_st_zero, m_axis_tvalid && !m_axis_tdata[111] |-> m_axis_tdata[153:112] == 42'd0, "stray store")

endmodule

bind five_stage_pipeline_core fspc_checker u_fspc_checker (.*);

`default_nettype wire

// ===== verif/five_stage_pipeline_core_checker.sv =====
`timescale 1ns / 1ps
module five_stage_pipeline_core_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_fire_i,
  input  logic [47:0]  in_data_i,
  input  logic [1:0]   in_cmd_i,
  input  logic         out_fire_i,
  input  logic [159:0] out_data_i,
  output int           fail_count_o,
  output int           pending_o
);

  localparam int Depth = 1024;

  logic [31:0] imem [Depth];
  logic [31:0] dmem [Depth];
  logic [31:0] regs [8];
  logic [9:0]  fetch_pc;
  logic [31:0] lat_ins [5];
  logic [9:0]  lat_pc [2];
  logic [31:0] dec_op [3];
  logic [31:0] ex_res [3];
  logic [31:0] wb_val [2];
  logic [2:0]  lat_dst [4];
  logic [31:0] clocks;
  logic        halt_seen;

  fspc_pkg::res_t outcome_q [$];

  function automatic fspc_pkg::op_e op_of(logic [31:0] w);
    return fspc_pkg::op_e'(w[24:22]);
  endfunction

  function automatic bit writes_reg(fspc_pkg::op_e o);
    return o == fspc_pkg::OP_ADD || o == fspc_pkg::OP_NOR || o == fspc_pkg::OP_LW;
  endfunction

  function automatic bit uses_a(fspc_pkg::op_e o);
    return o inside {fspc_pkg::OP_ADD, fspc_pkg::OP_NOR, fspc_pkg::OP_LW, fspc_pkg::OP_SW,
                     fspc_pkg::OP_BEQ};
  endfunction

  function automatic bit uses_b(fspc_pkg::op_e o);
    return o inside {fspc_pkg::OP_ADD, fspc_pkg::OP_NOR, fspc_pkg::OP_SW, fspc_pkg::OP_BEQ};
  endfunction

  task automatic clear_core();
    for (int i = 0; i < Depth; i++) begin
      imem[i] = '0;
      dmem[i] = '0;
    end
    for (int i = 0; i < 8; i++) regs[i] = '0;
    for (int i = 0; i < 5; i++) lat_ins[i] = fspc_pkg::NOOP_WORD;
    lat_pc = '{default: '0};
    dec_op = '{default: '0};
    ex_res = '{default: '0};
    wb_val = '{default: '0};
    lat_dst = '{default: '0};
    fetch_pc = '0;
    clocks = '0;
    halt_seen = 1'b0;
  endtask

  // Advances the pipeline model by one command and returns what the block reports.
  task automatic run_command(input fspc_pkg::cmd_e cmd, input logic [9:0] addr,
                             input logic [31:0] data, output fspc_pkg::res_t r);
    logic [31:0] ifid, idex, exmem, memwb, wbend, a, b;
    logic [31:0] ni [5];
    logic [9:0]  np [2];
    logic [31:0] nd [3];
    logic [31:0] ne [3];
    logic [31:0] nw [2];
    logic [2:0]  nt [4];
    logic [9:0]  nfetch;
    fspc_pkg::op_e oif, oid, oex, omw, owb;
    bit stall;
    r = '0;
    case (cmd)
      fspc_pkg::CMD_LOAD: begin
        imem[addr] = data;
        dmem[addr] = data;
      end
      fspc_pkg::CMD_READ_REG: r.read_value = regs[addr[2:0]];
      fspc_pkg::CMD_READ_MEM: r.read_value = dmem[addr];
      default: begin
        if (!halt_seen) begin
          ifid = lat_ins[0]; idex = lat_ins[1]; exmem = lat_ins[2];
          memwb = lat_ins[3]; wbend = lat_ins[4];
          oif = op_of(ifid); oid = op_of(idex); oex = op_of(exmem);
          omw = op_of(memwb); owb = op_of(wbend);
          ni = lat_ins; np = lat_pc; nd = dec_op; ne = ex_res; nw = wb_val; nt = lat_dst;
          nfetch = fetch_pc;
          // Load-use hazard holds fetch and decode and sends a bubble into execute.
          stall = 0;
          if (oid == fspc_pkg::OP_LW) begin
            if (oif inside {fspc_pkg::OP_ADD, fspc_pkg::OP_NOR, fspc_pkg::OP_BEQ,
                            fspc_pkg::OP_SW} &&
                (ifid[21:19] == idex[18:16] || ifid[18:16] == idex[18:16]))
              stall = 1;
            else if (oif == fspc_pkg::OP_LW && ifid[21:19] == idex[18:16])
              stall = 1;
          end
          if (stall) ni[1] = fspc_pkg::NOOP_WORD;
          else begin
            ni[0] = imem[fetch_pc];
            np[0] = fetch_pc + 10'd1;
            nfetch = np[0];
            ni[1] = ifid;
          end
          np[1] = lat_pc[0];
          nd[0] = regs[ifid[21:19]];
          nd[1] = regs[ifid[18:16]];
          nd[2] = {{16{ifid[15]}}, ifid[15:0]};
          if (oif == fspc_pkg::OP_ADD || oif == fspc_pkg::OP_NOR) nt[0] = ifid[2:0];
          else if (oif == fspc_pkg::OP_LW) nt[0] = ifid[18:16];
          // Execute, nearest forwarding source applied last.
          ni[2] = idex;
          ne[0] = {22'd0, lat_pc[1]} + dec_op[2];
          nt[1] = lat_dst[0];
          a = dec_op[0];
          b = dec_op[1];
          if (writes_reg(owb)) begin
            if (lat_dst[3] == idex[21:19] && uses_a(oid)) a = wb_val[1];
            if (lat_dst[3] == idex[18:16] && uses_b(oid)) b = wb_val[1];
          end
          if (writes_reg(omw)) begin
            if (lat_dst[2] == idex[21:19] && uses_a(oid)) a = wb_val[0];
            if (lat_dst[2] == idex[18:16] && uses_b(oid)) b = wb_val[0];
          end
          if (oex == fspc_pkg::OP_ADD || oex == fspc_pkg::OP_NOR) begin
            if (lat_dst[1] == idex[21:19] && uses_a(oid)) a = ex_res[1];
            if (lat_dst[1] == idex[18:16] && uses_b(oid)) b = ex_res[1];
          end
          case (oid)
            fspc_pkg::OP_ADD: ne[1] = a + b;
            fspc_pkg::OP_NOR: ne[1] = ~(a | b);
            fspc_pkg::OP_LW, fspc_pkg::OP_SW: ne[1] = a + dec_op[2];
            fspc_pkg::OP_BEQ: ne[1] = b - a;
            default: ;
          endcase
          ne[2] = b;
          // Memory stage; a taken branch squashes the three younger latches.
          ni[3] = exmem;
          nt[2] = lat_dst[1];
          case (oex)
            fspc_pkg::OP_ADD, fspc_pkg::OP_NOR: nw[0] = ex_res[1];
            fspc_pkg::OP_LW: nw[0] = dmem[ex_res[1][9:0]];
            fspc_pkg::OP_BEQ: begin
              if (ex_res[1] == 0) begin
                ni[0] = fspc_pkg::NOOP_WORD;
                ni[1] = fspc_pkg::NOOP_WORD;
                ni[2] = fspc_pkg::NOOP_WORD;
                nfetch = ex_res[0][9:0];
              end
            end
            fspc_pkg::OP_SW: begin
              nw[0] = ex_res[1];
              r.store_valid = 1;
              r.store_address = ex_res[1][9:0];
              r.store_value = ex_res[2];
              dmem[ex_res[1][9:0]] = ex_res[2];
            end
            default: ;
          endcase
          ni[4] = memwb;
          nt[3] = lat_dst[2];
          nw[1] = wb_val[0];
          if (writes_reg(omw)) begin
            r.reg_write_valid = 1;
            r.reg_write_index = lat_dst[2];
            r.reg_write_value = wb_val[0];
            regs[lat_dst[2]] = wb_val[0];
          end
          lat_ins = ni; lat_pc = np; dec_op = nd; ex_res = ne; wb_val = nw; lat_dst = nt;
          fetch_pc = nfetch;
          clocks = clocks + 1;
          halt_seen = op_of(ni[3]) == fspc_pkg::OP_HALT;
        end
      end
    endcase
    r.halted = halt_seen;
    r.program_counter = fetch_pc;
    r.cycle_count = clocks;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    clear_core();
  end

  always @(posedge clk_i) begin
    fspc_pkg::res_t r, want, got;
    if (rst_ni) begin
      if (in_fire_i) begin
        run_command(fspc_pkg::cmd_e'(in_cmd_i), in_data_i[9:0], in_data_i[41:10], r);
        outcome_q.push_back(r);
      end
      if (out_fire_i) begin
        // The result is packed with the halt flag in the lowest bit.
        got.halted          = out_data_i[0];
        got.program_counter = out_data_i[10:1];
        got.cycle_count     = out_data_i[42:11];
        got.read_value      = out_data_i[74:43];
        got.reg_write_valid = out_data_i[75];
        got.reg_write_index = out_data_i[78:76];
        got.reg_write_value = out_data_i[110:79];
        got.store_valid     = out_data_i[111];
        got.store_address   = out_data_i[121:112];
        got.store_value     = out_data_i[153:122];
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $time, out_data_i);
          fail_count_o++;
        end else begin
          want = outcome_q.pop_front();
          if (got != want || out_data_i[159:154] != '0) begin
            $display("%0t: mismatch expected %h actual %h (raw %h)", $time, want, got,
                     out_data_i);
            fail_count_o++;
          end
        end
      end
      pending_o = outcome_q.size();
    end
  end
endmodule

// ===== verif/five_stage_pipeline_core_tb.sv =====
`timescale 1ns / 1ps
module five_stage_pipeline_core_tb;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // address [9:0], data [41:10], zero fill up to 48 bits
  logic [47:0]  s_axis_tdata = '0;
  // command [1:0]
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // halted [0], program_counter [10:1], cycle_count [42:11], read_value [74:43],
  // reg_write_valid [75], reg_write_index [78:76], reg_write_value [110:79],
  // store_valid [111], store_address [121:112], store_value [153:122]
  logic [159:0] m_axis_tdata;

  int  fail_count, pending, quiet_cycles;
  bit  calm;  // During the calm stretch neither side idles.

  five_stage_pipeline_core uut (.*);

  five_stage_pipeline_core_checker chk (
    .clk_i, .rst_ni,
    .in_fire_i(s_axis_tvalid && s_axis_tready), .in_data_i(s_axis_tdata),
    .in_cmd_i(s_axis_tuser),
    .out_fire_i(m_axis_tvalid && m_axis_tready), .out_data_i(m_axis_tdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Receiver stalls at random except in the calm stretch.
  always @(negedge clk_i) m_axis_tready <= calm || ($urandom_range(99) >= 30);

  // The watchdog covers the memory clearing pass after reset.
  always @(posedge clk_i) begin
    if (rst_ni && !((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
      quiet_cycles++;
    else
      quiet_cycles = 0;
    if (quiet_cycles > 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sends one command; the caller is at a falling edge and tvalid stays high
  // on return so that the next command can follow without a gap.
  task automatic send(input fspc_pkg::cmd_e cmd, input logic [9:0] addr,
                      input logic [31:0] data);
    bit ready_seen;
    if (!calm) begin
      while ($urandom_range(99) < 30) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {6'd0, data, addr};
    // tready is read once the falling-edge updates have settled.
    forever begin
      #1;
      ready_seen = s_axis_tready;
      @(posedge clk_i);
      if (ready_seen) break;
      @(negedge clk_i);
    end
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] instr(fspc_pkg::op_e op, logic [2:0] ra, logic [2:0] rb,
                                        logic [15:0] off);
    return {7'd0, op, ra, rb, off};
  endfunction

  function automatic logic [31:0] rand_instr();
    fspc_pkg::op_e op;
    int  k;
    k = $urandom_range(99);
    if (k < 25) op = fspc_pkg::OP_ADD;
    else if (k < 40) op = fspc_pkg::OP_NOR;
    else if (k < 55) op = fspc_pkg::OP_LW;
    else if (k < 68) op = fspc_pkg::OP_SW;
    else if (k < 82) op = fspc_pkg::OP_BEQ;
    else if (k < 88) op = fspc_pkg::OP_JALR;
    else if (k < 90) op = fspc_pkg::OP_HALT;
    else op = fspc_pkg::OP_NOOP;
    return {7'($urandom), op, 3'($urandom), 3'($urandom),
            ($urandom_range(1) ? 16'($urandom_range(8)) - 16'd4 : 16'($urandom))};
  endfunction

  initial begin
    int steps;
    calm = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: data word and address extremes, a short program with forwarding,
    // load-use, store, taken branch, jalr and halt, then steps that end before halt.
    send(fspc_pkg::CMD_LOAD, 10'd1023, 32'hFFFF_FFFF);
    send(fspc_pkg::CMD_LOAD, 10'd512, 32'h8000_0000);
    send(fspc_pkg::CMD_LOAD, 10'd0, instr(fspc_pkg::OP_LW, 3'd0, 3'd1, 16'd1023));
    send(fspc_pkg::CMD_LOAD, 10'd1, instr(fspc_pkg::OP_ADD, 3'd1, 3'd1, 16'd2));
    send(fspc_pkg::CMD_LOAD, 10'd2, instr(fspc_pkg::OP_NOR, 3'd2, 3'd1, 16'd3));
    send(fspc_pkg::CMD_LOAD, 10'd3, instr(fspc_pkg::OP_SW, 3'd0, 3'd3, 16'hFFFF));
    send(fspc_pkg::CMD_LOAD, 10'd4, instr(fspc_pkg::OP_BEQ, 3'd0, 3'd0, 16'd2));
    send(fspc_pkg::CMD_LOAD, 10'd5, {7'h7F, fspc_pkg::OP_ADD, 3'd7, 3'd7, 16'd7});
    send(fspc_pkg::CMD_LOAD, 10'd7, instr(fspc_pkg::OP_JALR, 3'd1, 3'd2, 16'd0));
    send(fspc_pkg::CMD_LOAD, 10'd8, instr(fspc_pkg::OP_HALT, 3'd0, 3'd0, 16'd0));
    for (int i = 0; i < 12; i++) send(fspc_pkg::CMD_STEP, 10'd0, 32'd0);
    send(fspc_pkg::CMD_READ_REG, 10'h3FF, 32'd0);
    send(fspc_pkg::CMD_READ_REG, 10'd3, 32'hFFFF_FFFF);
    send(fspc_pkg::CMD_READ_MEM, 10'd1023, 32'd0);

    // Random: mostly programs loaded and stepped, with reads and stray loads mixed in.
    // Once halted the core stays halted, so later programs only exercise memory paths;
    // to keep the pipeline busy, halts are rare and programs are long.
    steps = 0;
    while (steps < 1800) begin
      int k;
      calm = (steps > 700 && steps < 900);
      k = $urandom_range(99);
      if (k < 55) send(fspc_pkg::CMD_STEP, 10'($urandom), 32'($urandom));
      else if (k < 80) send(fspc_pkg::CMD_LOAD, 10'($urandom_range(40)), rand_instr());
      else if (k < 85) send(fspc_pkg::CMD_LOAD, 10'($urandom), 32'($urandom));
      else if (k < 93) send(fspc_pkg::CMD_READ_REG, 10'($urandom), 32'($urandom));
      else send(fspc_pkg::CMD_READ_MEM, 10'($urandom), 32'($urandom));
      steps++;
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
